[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned OperandWidthDefault = 16;
  localparam int unsigned OpW = OperandWidthDefault;
  localparam int unsigned NumW = 2 * OpW + 1;
  localparam int unsigned DenW = 2 * OpW - 1;
  localparam int unsigned MagW = 2 * OpW + 1;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic signed [OpW-1:0] a_numerator;
    logic signed [OpW-1:0] a_denominator;
    logic signed [OpW-1:0] b_numerator;
    logic signed [OpW-1:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [NumW-1:0] result_numerator;
    logic [DenW-1:0]        result_denominator;
    logic [1:0]             status;
  } out_item_t;

  // Request and reply of the shared remainder/quotient unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Channel  Direction  Payload                Handshake
// in_      input      rau_pkg::in_item_t     in_valid / in_stall
// out_     output     rau_pkg::out_item_t    out_valid / out_stall
//
// One item at a time. The products are registered in S_MUL and the signed sum
// in S_SUM. Euclid then runs remainder steps on a shared restoring divider,
// each a start, one bit step per quotient bit and a done pulse; two quotient
// divisions, of the numerator and the denominator by the GCD, follow. An error
// or zero result skips the divider; otherwise the time an item takes is set
// by the number of remainder steps.
// Reset is synchronous and active low; a stalled result holds in out_item
// and the input is not taken again until it has been transferred.
module rational_arithmetic_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rau_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rau_pkg::out_item_t  out_item
);

  localparam int unsigned OpW  = rau_pkg::OpW;
  localparam int unsigned MagW = rau_pkg::MagW;
  localparam int unsigned DenW = rau_pkg::DenW;
  localparam int unsigned AbsW = OpW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_QN   = 3'd4;
  localparam logic [2:0] S_QD   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       sub_r, sub_nxt;

  logic [1:0]      kind_r;
  logic [AbsW-1:0] an_r, ad_r, bn_r, bd_r;
  logic            an_neg_r, bn_neg_r;
  logic [MagW-1:0] p1_r, p2_r, den_r;
  logic            p1_neg_r, p2_neg_r;
  logic [MagW-1:0] num_r, gx_r, gy_r;
  logic            num_neg_r;
  logic            out_valid_r;
  rau_pkg::out_item_t res_r;

  rau_pkg::div_ctl_t dctl;
  rau_pkg::div_sts_t dsts;
  logic [MagW-1:0]   ddvd, ddvs, dquo, drem;

  function automatic logic [AbsW-1:0] abs_of(input logic [OpW-1:0] v);
    logic [AbsW-1:0] e;
    e = {v[OpW-1], v};
    return v[OpW-1] ? AbsW'(-e) : e;
  endfunction

  logic [AbsW-1:0] in_an, in_ad, in_bn, in_bd;
  logic            in_zero_den, in_div_zero;
  assign in_an = abs_of(in_item.a_numerator);
  assign in_ad = abs_of(in_item.a_denominator);
  assign in_bn = abs_of(in_item.b_numerator);
  assign in_bd = abs_of(in_item.b_denominator);
  assign in_zero_den = (in_ad == '0) || (in_bd == '0);
  assign in_div_zero = (in_item.kind == rau_pkg::KIND_DIV) && (in_bn == '0);

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  rau_divider #(.W(MagW)) u_div (
    .clk, .rst_n, .ctl(dctl), .dividend(ddvd), .divisor(ddvs),
    .sts(dsts), .quotient(dquo), .remainder(drem)
  );

  logic [MagW-1:0] sum_mag;
  logic            sum_neg;
  always_comb begin
    if (p1_neg_r == p2_neg_r) begin
      sum_mag = p1_r + p2_r;
      sum_neg = p1_neg_r;
    end else if (p1_r >= p2_r) begin
      sum_mag = p1_r - p2_r;
      sum_neg = p1_neg_r;
    end else begin
      sum_mag = p2_r - p1_r;
      sum_neg = p2_neg_r;
    end
  end

  always_comb begin
    dctl.start = 1'b0;
    ddvd = gx_r;
    ddvs = gy_r;
    state_nxt = state_r;
    sub_nxt = 1'b0;
    unique case (state_r)
      S_GCD: begin
        dctl.start = !dsts.busy && !dsts.done && (gy_r != '0);
      end
      S_QN: begin
        // The greatest common divisor is left in gx once Euclid ends.
        ddvd = num_r;
        ddvs = gx_r;
        dctl.start = !dsts.busy && !dsts.done && !sub_r;
        sub_nxt = (sub_r || dctl.start) && !dsts.done;
      end
      S_QD: begin
        ddvd = den_r;
        ddvs = gx_r;
        dctl.start = !dsts.busy && !dsts.done && !sub_r;
        sub_nxt = (sub_r || dctl.start) && !dsts.done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            kind_r <= in_item.kind;
            an_r <= in_an;
            ad_r <= in_ad;
            bn_r <= in_bn;
            bd_r <= in_bd;
            an_neg_r <= (in_an != '0) &&
                        (in_item.a_numerator[OpW-1] != in_item.a_denominator[OpW-1]);
            bn_neg_r <= (in_bn != '0) &&
                        (in_item.b_numerator[OpW-1] != in_item.b_denominator[OpW-1]);
            if (in_zero_den || in_div_zero) begin
              res_r.result_numerator   <= '0;
              res_r.result_denominator <= DenW'(1);
              res_r.status <= in_zero_den ? rau_pkg::STATUS_ZERO_DEN
                                          : rau_pkg::STATUS_DIV_ZERO;
              out_valid_r <= 1'b1;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // p1 = an*bd (an*bn for multiply), p2 = bn*ad for add/subtract, else 0; den per kind.
          if (kind_r == rau_pkg::KIND_MUL) begin
            p1_r <= MagW'(an_r * bn_r);
            p1_neg_r <= an_neg_r != bn_neg_r;
            p2_r <= '0;
            p2_neg_r <= 1'b0;
            den_r <= MagW'(ad_r * bd_r);
          end else if (kind_r == rau_pkg::KIND_DIV) begin
            p1_r <= MagW'(an_r * bd_r);
            p1_neg_r <= an_neg_r != bn_neg_r;
            p2_r <= '0;
            p2_neg_r <= 1'b0;
            den_r <= MagW'(ad_r * bn_r);
          end else begin
            p1_r <= MagW'(an_r * bd_r);
            p1_neg_r <= an_neg_r;
            p2_r <= MagW'(bn_r * ad_r);
            p2_neg_r <= bn_neg_r ^ (kind_r == rau_pkg::KIND_SUB);
            den_r <= MagW'(ad_r * bd_r);
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          num_r <= sum_mag;
          num_neg_r <= sum_neg;
          gx_r <= sum_mag;
          gy_r <= den_r;
          if (sum_mag == '0) begin
            res_r.result_numerator   <= '0;
            res_r.result_denominator <= DenW'(1);
            res_r.status <= rau_pkg::STATUS_OK;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (dsts.done) begin
            gx_r <= gy_r;
            gy_r <= drem;
          end else if (!dsts.busy && gy_r == '0) begin
            state_r <= S_QN;
          end
        end
        S_QN: begin
          if (dsts.done) begin
            num_r <= dquo;
            state_r <= S_QD;
          end
        end
        S_QD: begin
          if (dsts.done) begin
            den_r <= dquo;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          res_r.result_numerator <= num_neg_r ? -num_r : num_r;
          res_r.result_denominator <= den_r[DenW-1:0];
          res_r.status <= rau_pkg::STATUS_OK;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/rau_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module rau_divider #(
  parameter int unsigned W = rau_pkg::MagW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rau_pkg::div_ctl_t ctl,
  input  logic [W-1:0]   dividend,
  input  logic [W-1:0]   divisor,
  output rau_pkg::div_sts_t sts,
  output logic [W-1:0]   quotient,
  output logic [W-1:0]   remainder
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_r, quo_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]    dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CntW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[dv/rational_arithmetic_unit_test.sv]
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;

  localparam int unsigned CycleLimit = 4000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rau_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  rau_pkg::out_item_t out_item;

  rau_pkg::out_item_t expected_fractions[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned hold_off_cycles;
  bit          calm;

  rational_arithmetic_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Works out the reduced fraction in plain 64-bit signed arithmetic; every
  // intermediate of 16-bit operands fits comfortably.
  function automatic rau_pkg::out_item_t compute_fraction(rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    longint          an, ad, bn, bd, num, den;
    longint unsigned mag, g;
    an = it.a_numerator;
    ad = it.a_denominator;
    bn = it.b_numerator;
    bd = it.b_denominator;
    r.result_numerator = '0;
    r.result_denominator = rau_pkg::DenW'(1);
    r.status = rau_pkg::STATUS_OK;
    if (ad == 0 || bd == 0) begin
      r.status = rau_pkg::STATUS_ZERO_DEN;
      return r;
    end
    if (it.kind == rau_pkg::KIND_DIV && bn == 0) begin
      r.status = rau_pkg::STATUS_DIV_ZERO;
      return r;
    end
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    case (it.kind)
      rau_pkg::KIND_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      rau_pkg::KIND_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      rau_pkg::KIND_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = (bn < 0) ? -(an * bd) : an * bd;
        den = ad * ((bn < 0) ? -bn : bn);
      end
    endcase
    if (num == 0) return r;
    mag = (num < 0) ? -num : num;
    g = euclid_gcd(mag, den);
    num = num / longint'(g);
    den = den / longint'(g);
    r.result_numerator = num[rau_pkg::NumW-1:0];
    r.result_denominator = den[rau_pkg::DenW-1:0];
    return r;
  endfunction

  task automatic send_item(input rau_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      in_item <= rau_pkg::in_item_t'({$urandom, $urandom, $urandom});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    expected_fractions.push_back(compute_fraction(it));
    sent_count++;
  endtask

  // Full-range values in four draws of ten, with the extremes and small values mixed in
  // so that common factors and exact cancellations turn up often.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3, 4:    return 16'($signed($urandom_range(24)) - 12);
      5:       return 16'($urandom_range(255) << $urandom_range(8));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rau_pkg::in_item_t random_item();
    rau_pkg::in_item_t it;
    it.kind = 2'($urandom_range(3));
    it.a_numerator = pick_operand();
    it.a_denominator = pick_operand();
    it.b_numerator = pick_operand();
    it.b_denominator = pick_operand();
    // Zero denominators only short-circuit the block, so keep them uncommon.
    if (it.a_denominator == 0 && $urandom_range(3) != 0) it.a_denominator = 1;
    if (it.b_denominator == 0 && $urandom_range(3) != 0) it.b_denominator = -1;
    return it;
  endfunction

  function automatic rau_pkg::in_item_t make_item(logic [1:0] k, int an, int ad, int bn,
                                                  int bd);
    rau_pkg::in_item_t it;
    it.kind = k;
    it.a_numerator = 16'(an);
    it.a_denominator = 16'(ad);
    it.b_numerator = 16'(bn);
    it.b_denominator = 16'(bd);
    return it;
  endfunction

  // Result side: checks each transfer and decides the stall for the next cycle.
  always @(posedge clk) begin
    rau_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (expected_fractions.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        error_count++;
      end else begin
        want = expected_fractions.pop_front();
        if (out_item.result_numerator !== want.result_numerator) begin
          $display("%0t: numerator expected %0d actual %0d", $time,
                   want.result_numerator, out_item.result_numerator);
          error_count++;
        end
        if (out_item.result_denominator !== want.result_denominator) begin
          $display("%0t: denominator expected %0d actual %0d", $time,
                   want.result_denominator, out_item.result_denominator);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_item.status);
          error_count++;
        end
      end
    end
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_fractions.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(make_item(rau_pkg::KIND_ADD, 1, 2, 1, 3));
    send_item(make_item(rau_pkg::KIND_SUB, 1, 2, 1, 2));
    send_item(make_item(rau_pkg::KIND_MUL, -3, 4, 4, -3));
    send_item(make_item(rau_pkg::KIND_DIV, 2, 3, -4, 9));
    send_item(make_item(rau_pkg::KIND_ADD, 5, 0, 1, 1));
    send_item(make_item(rau_pkg::KIND_DIV, 1, 1, 7, 0));
    send_item(make_item(rau_pkg::KIND_DIV, 3, 5, 0, 7));
    send_item(make_item(rau_pkg::KIND_MUL, 0, -7, 3, 5));
    send_item(make_item(rau_pkg::KIND_ADD, -32768, -32768, -32768, -32768));
    send_item(make_item(rau_pkg::KIND_SUB, 32767, -32768, -32768, 32767));
    send_item(make_item(rau_pkg::KIND_MUL, -32768, 1, -32768, 1));
    send_item(make_item(rau_pkg::KIND_DIV, -32768, 1, 1, -32768));
    send_item(make_item(rau_pkg::KIND_DIV, 32767, 32767, -32768, -32768));
    send_item(make_item(rau_pkg::KIND_ADD, 32767, 1, 32767, 1));
    send_item(make_item(rau_pkg::KIND_SUB, -32768, 1, 32767, 1));
    send_item(make_item(rau_pkg::KIND_MUL, 32767, 32766, 32766, 32767));
    send_item(make_item(rau_pkg::KIND_ADD, 1, -32768, 1, 32767));
    send_item(make_item(rau_pkg::KIND_SUB, 0, 5, 0, -5));
    send_item(make_item(rau_pkg::KIND_ADD, 1, 0, 1, 0));
    send_item(make_item(rau_pkg::KIND_DIV, 0, -1, 0, 1));
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_no_idling(input int unsigned count);
    calm = 1'b1;
    repeat (count) send_item(random_item());
    calm = 1'b0;
  endtask

  // The receiver holds off long enough that the block cannot take more input.
  task automatic test_back_pressure();
    hold_off_cycles = 3000;
    repeat (12) send_item(random_item());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    error_count = 0;
    cycle_count = 0;
    sent_count = 0;
    checked_count = 0;
    hold_off_cycles = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_back_pressure();
    test_no_idling(120);
    test_random(200);
    in_valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Sent %0d fraction pairs over all four operations, checked %0d results,",
             sent_count, checked_count);
    $display("including zero denominators, division by zero and a long output stall.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_test.sv
